### src/sdb_pkg.sv
// shared types and constants for the simplest dyadic between block
`timescale 1ns / 1ps

package sdb_pkg;

   localparam int NUM_W_DEF   = 32;
   localparam int MAX_EXP_DEF = 31;
   localparam int IN_NUM_W    = 32;
   localparam int EXP_W       = 5;
   localparam int RES_NUM_W   = 64;
   localparam int ALIGN_EXP   = 31;
   localparam int WIDE_W      = 64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SEARCH,
      ST_REDUCE
   } sdb_state_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_ZERO,
      RES_EQ,
      RES_SEARCH
   } sdb_res_type;

   typedef struct packed {
      logic        load;
      logic        reduce_init;
      logic        reduce_step;
      logic        setup;
      logic        search_step;
      logic        load_out;
      sdb_res_type res_sel;
   } sdb_cmd_type;

   typedef struct packed {
      logic a_gt_b;
      logic a_eq_b;
      logic straddle;
      logic reduce_done;
      logic hit;
      logic search_last;
      logic out_free;
   } sdb_status_type;

endpackage

### src/sdb_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface sdb_req_if import sdb_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [IN_NUM_W-1:0] left_num;
   logic        [EXP_W-1:0]    left_exp;
   logic signed [IN_NUM_W-1:0] right_num;
   logic        [EXP_W-1:0]    right_exp;

   modport source (output valid, left_num, left_exp, right_num, right_exp, input ready);
   modport sink (input valid, left_num, left_exp, right_num, right_exp, output ready);
endinterface

interface sdb_rsp_if import sdb_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic signed [RES_NUM_W-1:0] result_num;
   logic        [EXP_W-1:0]     result_exp;

   modport source (output valid, found, result_num, result_exp, input ready);
   modport sink (input valid, found, result_num, result_exp, output ready);
endinterface

### src/sdb_dp.sv
// datapath: bound alignment, classification, bit-serial search, reduction, output word
`timescale 1ns / 1ps

module sdb_dp import sdb_pkg::*; #(
   parameter int NUM_WIDTH = NUM_W_DEF,
   parameter int MAX_EXP   = MAX_EXP_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sdb_cmd_type                 cmd,
   output sdb_status_type              status,
   input  logic signed [IN_NUM_W-1:0]  left_num,
   input  logic        [EXP_W-1:0]     left_exp,
   input  logic signed [IN_NUM_W-1:0]  right_num,
   input  logic        [EXP_W-1:0]     right_exp,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic                        out_found,
   output logic signed [RES_NUM_W-1:0] out_num,
   output logic        [EXP_W-1:0]     out_exp
);

   logic signed [NUM_WIDTH-1:0] ln_trunc;
   logic signed [NUM_WIDTH-1:0] rn_trunc;
   logic signed [WIDE_W-1:0]    ln_wide;
   logic signed [WIDE_W-1:0]    rn_wide;

   logic signed [WIDE_W-1:0]    a_ff, a_in;
   logic signed [WIDE_W-1:0]    b_ff, b_in;
   logic signed [NUM_WIDTH-1:0] ln_ff, ln_in;
   logic        [EXP_W-1:0]     le_ff, le_in;

   logic signed [NUM_WIDTH-1:0] red_num_ff, red_num_in;
   logic        [EXP_W-1:0]     red_exp_ff, red_exp_in;

   logic                        neg_ff, neg_in;
   logic        [WIDE_W-1:0]    qlo_ff, qlo_in;
   logic        [WIDE_W-1:0]    qhi_ff, qhi_in;
   logic        [ALIGN_EXP-1:0] frac_lo_ff, frac_lo_in;
   logic        [ALIGN_EXP-1:0] frac_hi_ff, frac_hi_in;
   logic        [EXP_W-1:0]     cnt_ff, cnt_in;

   logic        [WIDE_W-1:0]    lo_setup;
   logic        [WIDE_W-1:0]    hm1_setup;

   logic                        out_valid_ff, out_valid_in;
   logic                        out_found_ff, out_found_in;
   logic signed [RES_NUM_W-1:0] out_num_ff, out_num_in;
   logic        [EXP_W-1:0]     out_exp_ff, out_exp_in;

   // sign extension from the configured numerator width
   assign ln_trunc = left_num[NUM_WIDTH-1:0];
   assign rn_trunc = right_num[NUM_WIDTH-1:0];
   assign ln_wide  = {{(WIDE_W-NUM_WIDTH){ln_trunc[NUM_WIDTH-1]}}, ln_trunc};
   assign rn_wide  = {{(WIDE_W-NUM_WIDTH){rn_trunc[NUM_WIDTH-1]}}, rn_trunc};

   // lo below hi, both non-negative after mirroring a negative pair
   assign lo_setup  = a_ff[WIDE_W-1] ? WIDE_W'(-b_ff) : WIDE_W'(a_ff);
   assign hm1_setup = a_ff[WIDE_W-1] ? WIDE_W'(~a_ff) : WIDE_W'(b_ff - WIDE_W'(1));

   always_comb begin
      a_in       = a_ff;
      b_in       = b_ff;
      ln_in      = ln_ff;
      le_in      = le_ff;
      red_num_in = red_num_ff;
      red_exp_in = red_exp_ff;
      neg_in     = neg_ff;
      qlo_in     = qlo_ff;
      qhi_in     = qhi_ff;
      frac_lo_in = frac_lo_ff;
      frac_hi_in = frac_hi_ff;
      cnt_in     = cnt_ff;
      if (cmd.load) begin
         a_in  = ln_wide <<< (EXP_W'(ALIGN_EXP) - left_exp);
         b_in  = rn_wide <<< (EXP_W'(ALIGN_EXP) - right_exp);
         ln_in = ln_trunc;
         le_in = left_exp;
      end
      if (cmd.reduce_init) begin
         red_num_in = ln_ff;
         red_exp_in = (ln_ff == '0) ? '0 : le_ff;
      end
      if (cmd.reduce_step) begin
         red_num_in = red_num_ff >>> 1;
         red_exp_in = red_exp_ff - EXP_W'(1);
      end
      if (cmd.setup) begin
         neg_in     = a_ff[WIDE_W-1];
         qlo_in     = lo_setup >> ALIGN_EXP;
         qhi_in     = hm1_setup >> ALIGN_EXP;
         frac_lo_in = lo_setup[ALIGN_EXP-1:0];
         frac_hi_in = hm1_setup[ALIGN_EXP-1:0];
         cnt_in     = '0;
      end
      if (cmd.search_step) begin
         qlo_in     = {qlo_ff[WIDE_W-2:0], frac_lo_ff[ALIGN_EXP-1]};
         qhi_in     = {qhi_ff[WIDE_W-2:0], frac_hi_ff[ALIGN_EXP-1]};
         frac_lo_in = frac_lo_ff << 1;
         frac_hi_in = frac_hi_ff << 1;
         cnt_in     = cnt_ff + EXP_W'(1);
      end
   end

   always_comb begin
      out_found_in = out_found_ff;
      out_num_in   = out_num_ff;
      out_exp_in   = out_exp_ff;
      if (cmd.load_out) begin
         case (cmd.res_sel)
            RES_ZERO: begin
               out_found_in = 1'b1;
               out_num_in   = '0;
               out_exp_in   = '0;
            end
            RES_EQ: begin
               out_found_in = 1'b1;
               out_num_in   = {{(RES_NUM_W-NUM_WIDTH){red_num_ff[NUM_WIDTH-1]}}, red_num_ff};
               out_exp_in   = red_exp_ff;
            end
            RES_SEARCH: begin
               out_found_in = 1'b1;
               // mirrored pair gives -(q + 1), which is ~q
               out_num_in   = neg_ff ? RES_NUM_W'(~qlo_ff) : RES_NUM_W'(qlo_ff + WIDE_W'(1));
               out_exp_in   = cnt_ff;
            end
            default: begin
               out_found_in = 1'b0;
               out_num_in   = '0;
               out_exp_in   = '0;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      ln_ff      <= ln_in;
      le_ff      <= le_in;
      red_num_ff <= red_num_in;
      red_exp_ff <= red_exp_in;
      neg_ff     <= neg_in;
      qlo_ff     <= qlo_in;
      qhi_ff     <= qhi_in;
      frac_lo_ff <= frac_lo_in;
      frac_hi_ff <= frac_hi_in;
      cnt_ff     <= cnt_in;
      out_found_ff <= out_found_in;
      out_num_ff   <= out_num_in;
      out_exp_ff   <= out_exp_in;
   end

   assign status.a_gt_b      = a_ff > b_ff;
   assign status.a_eq_b      = a_ff == b_ff;
   assign status.straddle    = a_ff[WIDE_W-1] && !b_ff[WIDE_W-1] && (b_ff != '0);
   assign status.reduce_done = (red_exp_ff == '0) || red_num_ff[0];
   assign status.hit         = qlo_ff < qhi_ff;
   assign status.search_last = cnt_ff == EXP_W'(MAX_EXP);
   assign status.out_free    = !out_valid_ff || out_ready;

   assign out_valid = out_valid_ff;
   assign out_found = out_found_ff;
   assign out_num   = out_num_ff;
   assign out_exp   = out_exp_ff;

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> out_valid_ff)
      else $error("output word not marked valid after load");

   a_empty_word_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_found_ff) |-> (out_num_ff == '0 && out_exp_ff == '0))
      else $error("word without a number carries nonzero fields");

   a_stalled_word_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> (out_valid_ff && $stable(out_found_ff) &&
                                        $stable(out_num_ff) && $stable(out_exp_ff)))
      else $error("stalled output word changed");

endmodule

### src/sdb_ctrl.sv
// controller state machine sequencing classify, search and reduction
`timescale 1ns / 1ps

module sdb_ctrl import sdb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  sdb_status_type status,
   output sdb_cmd_type    cmd
);

   sdb_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (status.a_gt_b || (!status.a_eq_b && status.straddle)) begin
               if (status.out_free) begin
                  state_in = ST_IDLE;
               end
            end else if (status.a_eq_b) begin
               state_in = ST_REDUCE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_REDUCE: begin
            if (status.reduce_done && status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if ((status.hit || status.search_last) && status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         ST_CLASSIFY: begin
            if (status.a_gt_b) begin
               cmd.res_sel  = RES_NONE;
               cmd.load_out = status.out_free;
            end else if (status.a_eq_b) begin
               cmd.reduce_init = 1'b1;
            end else if (status.straddle) begin
               cmd.res_sel  = RES_ZERO;
               cmd.load_out = status.out_free;
            end else begin
               cmd.setup = 1'b1;
            end
         end
         ST_REDUCE: begin
            if (status.reduce_done) begin
               cmd.res_sel  = RES_EQ;
               cmd.load_out = status.out_free;
            end else begin
               cmd.reduce_step = 1'b1;
            end
         end
         ST_SEARCH: begin
            if (status.hit) begin
               cmd.res_sel  = RES_SEARCH;
               cmd.load_out = status.out_free;
            end else if (status.search_last) begin
               cmd.res_sel  = RES_NONE;
               cmd.load_out = status.out_free;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_to_classify: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> state_ff == ST_CLASSIFY)
      else $error("accepted word did not start classification");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("output register overwritten while occupied");

   a_step_stays_in_search: assert property (@(posedge clock) disable iff (reset)
      cmd.search_step |=> state_ff == ST_SEARCH)
      else $error("search left early");

endmodule

### src/simplest_dyadic_between.sv
// Simplest dyadic rational between two dyadic bounds. Each request word carries
// left = left_num / 2^left_exp and right = right_num / 2^right_exp; the response
// word gives found and the simplest number between them in lowest terms. A word
// is answered straight from classification when left > right or the bounds
// straddle zero; for equal bounds k trailing zero bits are stripped, one per
// cycle, at most 31, and otherwise the search stops at the result exponent e;
// when no number fits the search runs to its end at MAX_EXP. The search finds
// one more binary digit of both bounds per cycle.
// The next request word is taken as soon as the current result sits in the
// output register; a stalled response holds the block only once the next
// result is ready.
`timescale 1ns / 1ps

module simplest_dyadic_between import sdb_pkg::*; #(
   parameter int NUM_WIDTH = NUM_W_DEF,
   parameter int MAX_EXP   = MAX_EXP_DEF
) (
   input  logic         clock,
   input  logic         reset,
   sdb_req_if.sink      req_ch,
   sdb_rsp_if.source    rsp_ch
);

   sdb_cmd_type    cmd;
   sdb_status_type status;

   sdb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .status   (status),
      .cmd      (cmd)
   );

   sdb_dp #(
      .NUM_WIDTH (NUM_WIDTH),
      .MAX_EXP   (MAX_EXP)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .left_num  (req_ch.left_num),
      .left_exp  (req_ch.left_exp),
      .right_num (req_ch.right_num),
      .right_exp (req_ch.right_exp),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_found (rsp_ch.found),
      .out_num   (rsp_ch.result_num),
      .out_exp   (rsp_ch.result_exp)
   );

endmodule
